/* src/fdr_pkg.sv */
// ----------------------------------------------------------------------------
// fdr_pkg
// shared types and constants of the fractional delay resampler
// ----------------------------------------------------------------------------
package fdr_pkg;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 17;

  localparam logic [CFG_INDEX_W-1:0] REG_MASTER_GAIN  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_CNT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DELAY_FRAMES = 2'd2;

  // register widths and reset values
  localparam int GAIN_W   = 17;
  localparam int CHCNT_W  = 6;
  localparam int DELAY_W  = 16;

  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 17'd65536;
  localparam logic [CHCNT_W-1:0] CHCNT_RESET = 6'd2;

  // item field widths
  localparam int SAMPLE_W = 16;
  localparam int CHAN_W   = 5;
  localparam int TRIM_W   = 18;
  localparam int STEP_W   = 26;
  localparam int OUT_W    = 24;
  localparam int STARV_W  = 32;

  // packed stream widths
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 56;

  // state widths, position is signed Q40.24
  localparam int FRAME_W = 40;
  localparam int FRAC_W  = 24;
  localparam int POS_W   = 64;

  // datapath widths
  localparam int TGAIN_W  = GAIN_W + TRIM_W;   // master gain times trim, Q32
  localparam int INTERP_W = 42;                 // interpolated value, 2^-39 units
  localparam int ROUND1_W = 26;                 // after first rounding, 2^-23 units
  localparam int SCALED_W = ROUND1_W + TGAIN_W + 1;
  localparam int ROUND2_W = SCALED_W - 32;

  // beat kind on tuser
  localparam logic FUNC_PUSH    = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR1,
    ST_ADDR2,
    ST_INTERP,
    ST_SCALE,
    ST_FINISH
  } fdr_state_t;

endpackage

/* src/fractional_delay_resampler_unit.sv */
// ----------------------------------------------------------------------------
// fractional_delay_resampler_unit
// linear interpolation resampler with start delay for one output route
// ----------------------------------------------------------------------------
//
//  channel   | direction | beat contents
//  ----------+-----------+---------------------------------------------------
//  s_*       | in        | push of one source sample or request of one output
//  m_*       | out       | one output sample per request beat
//  cfg_*     | in        | register write: master gain, channel count, delay
//
//  a push beat is taken in idle: the sample goes straight into the ring store
//  a request beat steps ADDR1, ADDR2, INTERP, SCALE, FINISH if a source frame
//  exists at the read position (two store reads on the single read port, then
//  interpolation and gain multiplies), and goes straight to FINISH if not
//  a finished result waits in the output register; a following request runs
//  up to its last step and holds there while m_tready stays low
//  rst is synchronous; the store is not cleared, frames become readable only
//  after being pushed
//
module fractional_delay_resampler_unit #(
  parameter int STORE_FRAMES = 2048,
  parameter int MAX_CHANNELS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // slave side
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // sample_in [15:0], source_channel [20:16], channel_trim [38:21],
  // resample_step [64:39], count_starvation [65], zero [71:66]
  input  logic [fdr_pkg::S_TDATA_W-1:0]       s_tdata,
  // func [0]
  input  logic                                s_tuser,
  // last_in_frame
  input  logic                                s_tlast,
  // master side
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // sample_out [23:0], starvation_count [55:24]
  output logic [fdr_pkg::M_TDATA_W-1:0]       m_tdata,
  // had_source [0]
  output logic                                m_tuser,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [fdr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [fdr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import fdr_pkg::*;

  // ring store geometry: slot index then channel index
  localparam int SLOT_W  = (STORE_FRAMES > 1) ? $clog2(STORE_FRAMES) : 1;
  localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ADDR_W  = SLOT_W + CH_W;
  localparam int DEPTH   = STORE_FRAMES << CH_W;

  localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(STORE_FRAMES - 1);
  localparam logic [SLOT_W:0]    SLOT_SPAN = (SLOT_W+1)'(STORE_FRAMES);
  localparam logic [FRAME_W-1:0] AGE_SPAN  = FRAME_W'(STORE_FRAMES);
  localparam logic [CHCNT_W-1:0] CH_MAX    = CHCNT_W'(MAX_CHANNELS);

  // --------------------------------------------------------------------------
  // beat fields
  // --------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] in_sample;
  logic [CHAN_W-1:0]   in_chan;
  logic [TRIM_W-1:0]   in_trim;
  logic [STEP_W-1:0]   in_step;
  logic                in_count;

  assign in_sample = s_tdata[15:0];
  assign in_chan   = s_tdata[20:16];
  assign in_trim   = s_tdata[38:21];
  assign in_step   = s_tdata[64:39];
  assign in_count  = s_tdata[65];

  // --------------------------------------------------------------------------
  // configuration and frame bookkeeping
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0]  master_gain;
  logic [CHCNT_W-1:0] chan_cnt;
  logic [CHCNT_W-1:0] chan_n;        // count clamped to 1 .. MAX_CHANNELS

  logic [FRAME_W-1:0] end_frame;
  logic [SLOT_W-1:0]  end_slot;      // end_frame modulo STORE_FRAMES
  logic [CHAN_W-1:0]  push_channel;
  logic [POS_W-1:0]   read_position;
  logic [STARV_W-1:0] starved_frames;

  always_comb begin
    priority if (chan_cnt == '0) begin
      chan_n = CHCNT_W'(1);
    end else if (chan_cnt > CH_MAX) begin
      chan_n = CH_MAX;
    end else begin
      chan_n = chan_cnt;
    end
  end

  // --------------------------------------------------------------------------
  // control
  // --------------------------------------------------------------------------
  fdr_state_t state, state_next;

  logic in_beat;
  logic push_beat;
  logic req_beat;
  logic out_load;
  logic mem_re;

  // request context
  logic                req_have;
  logic                req_delaying;
  logic                req_last;
  logic                req_count;
  logic [CHAN_W-1:0]   req_chan;
  logic [STEP_W-1:0]   req_step;
  logic [FRAC_W-1:0]   req_frac;
  logic [TGAIN_W-1:0]  req_gain;
  logic [FRAME_W-1:0]  req_age;      // end_frame minus the first frame

  assign in_beat   = s_tvalid && s_tready;
  assign push_beat = in_beat && (s_tuser == FUNC_PUSH);
  assign req_beat  = in_beat && (s_tuser == FUNC_REQUEST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mem_re     = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // no beat is taken while reset is held
        s_tready = !rst;
        if (req_beat) begin
          // without a source frame there is nothing to read
          if (!read_position[POS_W-1] && (read_position[POS_W-1:FRAC_W] < end_frame)) begin
            state_next = ST_ADDR1;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_ADDR1: begin
        mem_re     = 1'b1;
        state_next = ST_ADDR2;
      end
      ST_ADDR2: begin
        mem_re     = 1'b1;
        state_next = ST_INTERP;
      end
      ST_INTERP: begin
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // ring store, one write and one registered read per cycle
  // --------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] store [DEPTH];
  logic [SAMPLE_W-1:0] rd_data;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr;

  logic [SLOT_W:0]     slot_diff;
  logic [SLOT_W-1:0]   slot_first;
  logic [SLOT_W-1:0]   slot_a;
  logic [SLOT_W-1:0]   slot_second;
  logic                ok_first;
  logic                ok_second;
  logic                clamp_second;

  assign wr_addr = {end_slot, push_channel[CH_W-1:0]};

  // slot of the first frame: end slot stepped back by the age, wrapping
  assign slot_diff  = {1'b0, end_slot} - {1'b0, req_age[SLOT_W-1:0]};
  assign slot_first = slot_diff[SLOT_W] ? SLOT_W'(slot_diff + SLOT_SPAN)
                                        : slot_diff[SLOT_W-1:0];

  // second frame is the next one, or the first again at the newest frame
  always_comb begin
    priority if (clamp_second) begin
      slot_second = slot_a;
    end else if (slot_a == SLOT_LAST) begin
      slot_second = '0;
    end else begin
      slot_second = slot_a + SLOT_W'(1);
    end
  end

  assign rd_addr = (state == ST_ADDR1) ? {slot_first, req_chan[CH_W-1:0]}
                                       : {slot_second, req_chan[CH_W-1:0]};

  always_ff @(posedge clk) begin
    if (push_beat) begin
      store[wr_addr] <= in_sample;
    end
    if (mem_re) begin
      rd_data <= store[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // datapath
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0]  s1;
  logic signed [SAMPLE_W-1:0]  s2;
  logic signed [SAMPLE_W:0]    s_delta;
  logic signed [FRAC_W:0]      frac_s;
  logic signed [INTERP_W-1:0]  interp_prod;
  logic signed [INTERP_W-1:0]  interp_base;
  logic signed [INTERP_W-1:0]  interp;
  logic signed [INTERP_W-1:0]  interp_rsum;
  logic signed [ROUND1_W-1:0]  interp_rnd;
  logic signed [TGAIN_W:0]     gain_s;
  logic signed [SCALED_W-1:0]  scaled_prod;
  logic signed [SCALED_W-1:0]  scaled;
  logic signed [SCALED_W-1:0]  scaled_rsum;
  logic signed [ROUND2_W-1:0]  scaled_rnd;
  logic [OUT_W-1:0]            sat_value;
  logic                        ch_ok;

  assign ch_ok = {1'b0, req_chan} < chan_n;

  // s1 * 2^24 + (s2 - s1) * frac
  assign s2          = ok_second ? $signed(rd_data) : '0;
  assign s_delta     = $signed({s2[SAMPLE_W-1], s2}) - $signed({s1[SAMPLE_W-1], s1});
  assign frac_s      = $signed({1'b0, req_frac});
  assign interp_prod = s_delta * frac_s;
  assign interp_base = $signed({{(INTERP_W-SAMPLE_W-FRAC_W){s1[SAMPLE_W-1]}}, s1,
                                {FRAC_W{1'b0}}});

  // round half up to 2^-23, then apply master gain times trim
  assign interp_rsum = interp + INTERP_W'(32768);
  assign interp_rnd  = interp_rsum[INTERP_W-1:16];
  assign gain_s      = $signed({1'b0, req_gain});
  assign scaled_prod = interp_rnd * gain_s;

  // round half up by 32 bits and saturate to q1.23
  assign scaled_rsum = scaled + SCALED_W'(64'h8000_0000);
  assign scaled_rnd  = scaled_rsum[SCALED_W-1:32];

  always_comb begin
    priority if (scaled_rnd > ROUND2_W'(8388607)) begin
      sat_value = 24'h7F_FFFF;
    end else if (scaled_rnd < -$signed(ROUND2_W'(8388608))) begin
      sat_value = 24'h80_0000;
    end else begin
      sat_value = scaled_rnd[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (req_beat) begin
      req_delaying <= read_position[POS_W-1];
      req_have     <= !read_position[POS_W-1] &&
                      (read_position[POS_W-1:FRAC_W] < end_frame);
      req_last     <= s_tlast;
      req_count    <= in_count;
      req_chan     <= in_chan;
      req_step     <= in_step;
      req_frac     <= read_position[FRAC_W-1:0];
      req_gain     <= master_gain * in_trim;
      req_age      <= end_frame - read_position[POS_W-1:FRAC_W];
    end
    unique case (state)
      ST_ADDR1: begin
        slot_a       <= slot_first;
        clamp_second <= (req_age == FRAME_W'(1));
        ok_first     <= ch_ok && (req_age < AGE_SPAN);
        ok_second    <= ch_ok && (req_age <= AGE_SPAN);
      end
      ST_ADDR2: begin
        s1 <= ok_first ? $signed(rd_data) : '0;
      end
      ST_INTERP: begin
        interp <= interp_base + interp_prod;
      end
      ST_SCALE: begin
        scaled <= scaled_prod;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // position, starvation and output register
  // --------------------------------------------------------------------------
  logic [STARV_W-1:0] starved_next;
  logic [POS_W-1:0]   position_next;

  always_comb begin
    starved_next  = starved_frames;
    position_next = read_position;
    if (req_last) begin
      if (req_delaying || req_have) begin
        position_next = read_position + POS_W'(req_step);
      end else if (req_count && (starved_frames != '1)) begin
        starved_next = starved_frames + STARV_W'(1);
      end
    end
  end

  logic [OUT_W-1:0]   out_sample;
  logic               out_had;
  logic [STARV_W-1:0] out_starved;

  assign m_tdata = {out_starved, out_sample};
  assign m_tuser = out_had;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample  <= req_have ? sat_value : '0;
      out_had     <= req_have;
      out_starved <= starved_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid       <= 1'b0;
      master_gain    <= GAIN_RESET;
      chan_cnt       <= CHCNT_RESET;
      end_frame      <= '0;
      end_slot       <= '0;
      push_channel   <= '0;
      read_position  <= '0;
      starved_frames <= '0;
    end else begin
      // output beat register
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (out_load) begin
        read_position  <= position_next;
        starved_frames <= starved_next;
      end

      // a full frame moves the end frame and its slot on
      if (push_beat) begin
        if ({1'b0, push_channel} + CHCNT_W'(1) >= chan_n) begin
          push_channel <= '0;
          end_frame    <= end_frame + FRAME_W'(1);
          if ((end_frame == '1) || (end_slot == SLOT_LAST)) begin
            end_slot <= '0;
          end else begin
            end_slot <= end_slot + SLOT_W'(1);
          end
        end else begin
          push_channel <= push_channel + CHAN_W'(1);
        end
      end

      // the user must write only while idle; the block itself does not enforce it
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MASTER_GAIN: begin
            master_gain <= cfg_data[GAIN_W-1:0];
          end
          REG_CHANNEL_CNT: begin
            chan_cnt     <= cfg_data[CHCNT_W-1:0];
            push_channel <= '0;
          end
          REG_DELAY_FRAMES: begin
            read_position <= '0 - {{(POS_W-DELAY_W-FRAC_W){1'b0}},
                                   cfg_data[DELAY_W-1:0], {FRAC_W{1'b0}}};
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the fractional delay resampler against its own interpolation model:
// directed beats for saturation, delay, starvation, edge frames and unused
// channels, then random frame-shaped traffic under several register settings
// ----------------------------------------------------------------------------
module testbench;
  import fdr_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0]   sample;
    logic               had_source;
    logic [STARV_W-1:0] starved;
  } output_beat_t;

  class resampler_scoreboard;
    localparam int STORE_FRAMES = 2048;
    localparam int MAX_CHANNELS = 32;

    logic signed [SAMPLE_W-1:0] ring [0:STORE_FRAMES*MAX_CHANNELS-1];
    bit                         written [0:STORE_FRAMES*MAX_CHANNELS-1];
    logic [FRAME_W-1:0]         end_frame;
    int                         push_ch;
    logic [POS_W-1:0]           read_pos;
    logic [STARV_W-1:0]         starved;
    logic [GAIN_W-1:0]          master_gain;
    logic [CHCNT_W-1:0]         chan_reg;
    output_beat_t               pending_samples [$];
    int                         errors;

    function new();
      foreach (written[i]) written[i] = 1'b0;
      end_frame   = '0;
      push_ch     = 0;
      read_pos    = '0;
      starved     = '0;
      master_gain = GAIN_RESET;
      chan_reg    = CHCNT_RESET;
      errors      = 0;
    endfunction

    function int active_channels();
      if (chan_reg == 0) return 1;
      if (chan_reg > MAX_CHANNELS) return MAX_CHANNELS;
      return chan_reg;
    endfunction

    function int slot_index(longint unsigned frame, int chn);
      return int'((frame % STORE_FRAMES) * MAX_CHANNELS + chn);
    endfunction

    function bit readable(longint unsigned frame, int chn);
      longint unsigned e;
      e = end_frame;
      return frame < e && chn < active_channels() && (e - frame) < STORE_FRAMES;
    endfunction

    function longint fetch(longint unsigned frame, int chn);
      if (!readable(frame, chn)) return 0;
      return ring[slot_index(frame, chn)];
    endfunction

    function void locate_frames(output bit delaying, output bit have,
                                output longint unsigned first,
                                output longint unsigned second);
      longint unsigned e;
      e        = end_frame;
      delaying = read_pos[POS_W-1];
      first    = read_pos >> FRAC_W;
      have     = !delaying && first < e;
      second   = first + 1;
      if (have && second > e - 1) second = e - 1;
    endfunction

    // a request that would land on a store entry never pushed
    function bit reads_unwritten(int chn);
      bit delaying, have;
      longint unsigned first, second;
      locate_frames(delaying, have, first, second);
      if (!have) return 1'b0;
      return (readable(first, chn) && !written[slot_index(first, chn)]) ||
             (readable(second, chn) && !written[slot_index(second, chn)]);
    endfunction

    function longint round_half_up(longint v, int n);
      longint half;
      half = longint'(1) << (n - 1);
      return (v + half) >>> n;
    endfunction

    function int pending();
      return pending_samples.size();
    endfunction

    function void apply_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MASTER_GAIN: master_gain = data[GAIN_W-1:0];
        REG_CHANNEL_CNT: begin
          chan_reg = data[CHCNT_W-1:0];
          push_ch  = 0;
        end
        REG_DELAY_FRAMES: read_pos = 64'd0 - ({48'd0, data[DELAY_W-1:0]} << FRAC_W);
        default: ;
      endcase
    endfunction

    function void accept_beat(logic func, logic [SAMPLE_W-1:0] sample,
                              logic [CHAN_W-1:0] chn, logic [TRIM_W-1:0] trim,
                              logic last, logic [STEP_W-1:0] step, logic count);
      bit delaying, have;
      longint unsigned first, second;
      longint s1, s2, frac, acc, gain;
      output_beat_t want;
      if (func == FUNC_PUSH) begin
        ring[slot_index(end_frame, push_ch)]    = sample;
        written[slot_index(end_frame, push_ch)] = 1'b1;
        push_ch++;
        if (push_ch >= active_channels()) begin
          push_ch   = 0;
          end_frame = end_frame + 1'b1;
        end
        return;
      end
      locate_frames(delaying, have, first, second);
      acc = 0;
      if (have) begin
        s1   = fetch(first, chn);
        s2   = fetch(second, chn);
        frac = read_pos[FRAC_W-1:0];
        acc  = s1 * (longint'(1) << FRAC_W) + (s2 - s1) * frac;
        acc  = round_half_up(acc, 16);
        gain = master_gain;
        gain = gain * trim;
        acc  = round_half_up(acc * gain, 32);
        if (acc > 8388607) acc = 8388607;
        if (acc < -8388608) acc = -8388608;
      end
      if (last) begin
        if (delaying || have) read_pos = read_pos + step;
        else if (count && starved != {STARV_W{1'b1}}) starved = starved + 1'b1;
      end
      want.sample     = acc[OUT_W-1:0];
      want.had_source = have;
      want.starved    = starved;
      pending_samples = {pending_samples, want};
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function void check_output(logic [M_TDATA_W-1:0] tdata, logic tuser);
      output_beat_t want;
      if (pending_samples.size() == 0) begin
        note_error($sformatf("output beat %h/%b with nothing expected", tdata, tuser));
        return;
      end
      want = pending_samples.pop_front();
      if (tdata[OUT_W-1:0] !== want.sample)
        note_error($sformatf("sample_out expected %0d got %0d",
                             $signed(want.sample), $signed(tdata[OUT_W-1:0])));
      if (tuser !== want.had_source)
        note_error($sformatf("had_source expected %b got %b", want.had_source, tuser));
      if (tdata[M_TDATA_W-1:OUT_W] !== want.starved)
        note_error($sformatf("starvation_count expected %0d got %0d",
                             want.starved, tdata[M_TDATA_W-1:OUT_W]));
    endfunction
  endclass

  // index with no register behind it, writes must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [STEP_W-1:0]      STEP_ONE   = 26'd16777216;  // one frame, Q2.24
  localparam logic [STEP_W-1:0]      STEP_MAX   = 26'd33554432;  // two frames
  localparam logic [TRIM_W-1:0]      TRIM_UNITY = 18'd65536;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  wire                    s_tready;
  logic [S_TDATA_W-1:0]   s_tdata   = '0;
  logic                   s_tuser   = 1'b0;
  logic                   s_tlast   = 1'b0;
  wire                    m_tvalid;
  logic                   m_tready  = 1'b0;
  wire  [M_TDATA_W-1:0]   m_tdata;
  wire                    m_tuser;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // idle chance per cycle, in percent, for the sender and the receiver
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  resampler_scoreboard scoreboard;

  fractional_delay_resampler_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #5_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // receiver: check each accepted output beat, then roll the next stall
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) scoreboard.check_output(m_tdata, m_tuser);
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // one input beat; the predictor is updated at the accepting edge so the
  // next beat is always generated from current state
  task automatic send_beat(input logic func, input logic [SAMPLE_W-1:0] sample,
                           input logic [CHAN_W-1:0] chn, input logic [TRIM_W-1:0] trim,
                           input logic last, input logic [STEP_W-1:0] step,
                           input logic count);
    // never point a request at a store entry that was never pushed;
    // channel 0 is always present in a completed frame
    if (func == FUNC_REQUEST && scoreboard.reads_unwritten(chn)) chn = '0;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, count, step, trim, chn, sample};
    s_tuser  <= func;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    scoreboard.accept_beat(func, sample, chn, trim, last, step, count);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] rand_step();
    case ($urandom_range(9))
      0:       return '0;
      1:       return STEP_W'($urandom_range(STEP_MAX));
      2:       return STEP_MAX;
      default: return STEP_W'($urandom_range(25165824, 8388608));  // half to one and a half
    endcase
  endfunction

  // push beats carry junk in the unused fields
  task automatic push_sample(input logic [SAMPLE_W-1:0] sample);
    send_beat(FUNC_PUSH, sample, CHAN_W'($urandom), TRIM_W'($urandom),
              1'($urandom_range(1)), STEP_W'($urandom), 1'($urandom_range(1)));
  endtask

  task automatic request_sample(input logic [CHAN_W-1:0] chn, input logic [TRIM_W-1:0] trim,
                                input logic last, input logic [STEP_W-1:0] step,
                                input logic count);
    send_beat(FUNC_REQUEST, SAMPLE_W'($urandom), chn, trim, last, step, count);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    scoreboard.apply_register(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // hold the sender until every expected sample is back, then let a push
  // still in flight settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (scoreboard.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // random traffic: mostly whole source frames followed by one output frame,
  // pushed so that the ring stays a little ahead of the read position, with
  // some stray beats of any kind mixed in
  task automatic run_traffic(input int n_items);
    int                sent;
    int                frames;
    int                chans;
    int                k;
    longint            gap;
    logic [CHAN_W-1:0] chn;
    logic [TRIM_W-1:0] trim;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 12) begin
        send_beat(1'($urandom_range(1)), rand_sample(), CHAN_W'($urandom),
                  TRIM_W'($urandom), 1'($urandom_range(1)), rand_step(),
                  1'($urandom_range(1)));
        sent++;
      end else begin
        if (scoreboard.read_pos[POS_W-1]) gap = 8;
        else gap = longint'(scoreboard.end_frame) - longint'(scoreboard.read_pos >> FRAC_W);
        // now and then let the reader run dry
        if ($urandom_range(99) < 6) frames = 0;
        else if (gap < 3) frames = $urandom_range(3, 1);
        else frames = $urandom_range(1);
        repeat (frames * scoreboard.active_channels()) begin
          push_sample(rand_sample());
          sent++;
        end
        chans = $urandom_range(3, 1);
        for (k = 0; k < chans; k++) begin
          if ($urandom_range(9) != 0)
            chn = CHAN_W'($urandom_range(scoreboard.active_channels() - 1));
          else chn = CHAN_W'($urandom);
          if ($urandom_range(3) != 0) trim = TRIM_W'($urandom_range(70000, 60000));
          else trim = TRIM_W'($urandom);
          request_sample(chn, trim, k == chans - 1, rand_step(), 1'($urandom_range(1)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    scoreboard  = new();
    tx_idle_pct = 8;
    rx_idle_pct = 63;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed, reset settings: unity gain, two channels, no delay
    // nothing pushed yet: starved, counted only when asked
    request_sample(5'd0, TRIM_UNITY, 1'b1, STEP_ONE, 1'b1);
    request_sample(5'd1, TRIM_UNITY, 1'b1, STEP_ONE, 1'b0);
    // three frames of extreme samples
    push_sample(16'h7fff);
    push_sample(16'h8000);
    push_sample(16'h8000);
    push_sample(16'h7fff);
    push_sample(16'h0001);
    push_sample(16'hffff);
    // full trim saturates both ways, unused channel reads zero
    request_sample(5'd0, 18'h3ffff, 1'b0, '0, 1'b0);
    request_sample(5'd1, 18'h3ffff, 1'b0, '0, 1'b0);
    request_sample(5'd5, TRIM_UNITY, 1'b0, '0, 1'b0);
    // zero trim, then the largest step
    request_sample(5'd1, '0, 1'b1, STEP_MAX, 1'b0);
    // half a frame past the newest frame: second frame clamps to end - 1
    request_sample(5'd0, TRIM_UNITY, 1'b1, 26'h0800000, 1'b1);
    request_sample(5'd0, TRIM_UNITY, 1'b0, '0, 1'b0);
    // one more frame: true interpolation, then run past the end
    push_sample(16'd100);
    push_sample(16'd200);
    request_sample(5'd0, TRIM_UNITY, 1'b1, 26'h1ffffff, 1'b0);
    request_sample(5'd1, TRIM_UNITY, 1'b1, '0, 1'b1);
    request_sample(5'd31, 18'h3ffff, 1'b1, '0, 1'b1);
    // start delay: silent frames that still advance, counting ignored
    wait_idle();
    write_register(REG_DELAY_FRAMES, 17'd2);
    request_sample(5'd0, TRIM_UNITY, 1'b1, STEP_ONE, 1'b1);
    request_sample(5'd0, TRIM_UNITY, 1'b1, STEP_ONE, 1'b1);
    request_sample(5'd0, TRIM_UNITY, 1'b1, STEP_ONE, 1'b0);

    // stereo with a short delay that is crossed during the phase
    wait_idle();
    write_register(REG_MASTER_GAIN, GAIN_RESET);
    write_register(REG_CHANNEL_CNT, {11'h5a5, 6'd2});
    write_register(REG_DELAY_FRAMES, 17'd3);
    run_traffic(260);

    // mono, muted, stray write to the unused index
    wait_idle();
    write_register(REG_MASTER_GAIN, '0);
    write_register(REG_CHANNEL_CNT, 17'd1);
    write_register(REG_DELAY_FRAMES, '0);
    write_register(REG_UNUSED, CFG_DATA_W'($urandom));
    run_traffic(260);

    // slow sender, quick receiver
    tx_idle_pct = 63;
    rx_idle_pct = 8;
    wait_idle();
    write_register(REG_MASTER_GAIN, 17'd65535);
    write_register(REG_CHANNEL_CNT, 17'd32);
    run_traffic(300);

    // count of zero acts as one, longest delay keeps every request silent
    wait_idle();
    write_register(REG_MASTER_GAIN, 17'd40000);
    write_register(REG_CHANNEL_CNT, '0);
    write_register(REG_DELAY_FRAMES, 17'h0ffff);
    run_traffic(120);

    // no idling on either side from here on
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    wait_idle();
    // count above the maximum acts as the maximum
    write_register(REG_MASTER_GAIN, GAIN_RESET);
    write_register(REG_CHANNEL_CNT, 17'd63);
    write_register(REG_DELAY_FRAMES, 17'd1);
    run_traffic(260);

    wait_idle();
    write_register(REG_MASTER_GAIN, CFG_DATA_W'($urandom_range(GAIN_RESET)));
    write_register(REG_CHANNEL_CNT, {11'h3ff, 6'd5});
    write_register(REG_DELAY_FRAMES, '0);
    run_traffic(200);

    wait_idle();
    repeat (10) @(posedge clk);
    if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

/* fractional_delay_resampler_unit.f */
src/fdr_pkg.sv
src/fractional_delay_resampler_unit.sv
bench/testbench.sv
